@@ design/ptc_pkg.sv @@
package ptc_pkg;

   typedef logic [31:0] word_type;

   localparam int CSR_INDEX_W = 3;
   localparam int COEF_COUNT  = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_AC1_AC2 = 3'd0,
      CSR_AC3_AC4 = 3'd1,
      CSR_AC5_AC6 = 3'd2,
      CSR_B1_B2   = 3'd3,
      CSR_MC_MD   = 3'd4,
      CSR_OSS     = 3'd5
   } csr_index_type;

   localparam logic [1:0] OSS_RESET   = 2'd3;
   localparam word_type   T_OFFSET    = 32'd4000;
   localparam word_type   K_3038      = 32'd3038;
   localparam word_type   K_NEG_7357  = 32'hFFFF_E343;
   localparam word_type   K_3791      = 32'd3791;
   localparam word_type   K_50000     = 32'd50000;
   localparam word_type   K_32768     = 32'd32768;
   localparam word_type   K_ROUND_T   = 32'd8;
   localparam word_type   K_ROUND_B3  = 32'd2;
   localparam word_type   K_ROUND_X3  = 32'd2;

   function automatic word_type sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // low word of the product, same bits for signed or unsigned operands
   function automatic word_type mul32(input word_type a, input word_type b);
      word_type r;
      r = a * b;
      return r;
   endfunction

   function automatic word_type asr32(input word_type x, input int n);
      return word_type'($signed(x) >>> n);
   endfunction

   // truncating signed division by 2**k
   function automatic word_type sdiv_p2(input word_type a, input int k);
      word_type bias;
      bias = a[31] ? ((word_type'(1) << k) - word_type'(1)) : '0;
      return asr32(a + bias, k);
   endfunction

endpackage

@@ design/ptc_udiv.sv @@
module ptc_udiv
   import ptc_pkg::*;
#(
   parameter int WIDTH  = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [WIDTH-1:0]  num,
   input  logic [WIDTH-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [WIDTH-1:0]  quo,
   output logic [SIDE_W-1:0] side_out
);

   logic              valid_ff [WIDTH];
   logic [WIDTH-1:0]  rem_ff   [WIDTH];
   logic [WIDTH-1:0]  qn_ff    [WIDTH];
   logic [WIDTH-1:0]  den_ff   [WIDTH];
   logic [SIDE_W-1:0] side_ff  [WIDTH];

   // one quotient bit per stage, restoring
   for (genvar k = 0; k < WIDTH; k++) begin : g_step
      logic              v_prev;
      logic [WIDTH-1:0]  rem_prev, qn_prev, den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [WIDTH:0]    trial;
      logic              fits;
      logic [WIDTH:0]    diff;
      logic [WIDTH-1:0]  rem_in, qn_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign qn_prev   = num;
         assign den_prev  = den;
         assign side_prev = side_in;
      end else begin : g_next
         assign v_prev    = valid_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign qn_prev   = qn_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign trial  = {rem_prev, qn_prev[WIDTH-1]};
      assign fits   = trial >= {1'b0, den_prev};
      assign diff   = trial - {1'b0, den_prev};
      assign rem_in = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      assign qn_in  = {qn_prev[WIDTH-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_prev;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            qn_ff[k]   <= qn_in;
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[WIDTH-1];
   assign quo       = qn_ff[WIDTH-1];
   assign side_out  = side_ff[WIDTH-1];

   for (genvar k = 0; k < WIDTH; k++) begin : g_chk
      a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
         valid_ff[k] && den_ff[k] != '0 |-> rem_ff[k] < den_ff[k])
         else $error("partial remainder not below divisor");
   end

endmodule

@@ design/pressure_temperature_compensation.sv @@
// Integer barometric compensation pipeline. Each request beat carries a raw 16-bit temperature
// word and a raw 24-bit pressure reading; each response beat returns the temperature in 0.1 degC,
// the pressure in Pa and a divide error flag (results forced to zero when a divisor is zero).
// One beat is taken every cycle unless stalled. Stages: an input stage, a 32-stage temperature
// divider, six multiply/shift stages, a 32-stage pressure divider, three polynomial stages and
// the output register. The whole pipeline advances together whenever the output register is
// empty or being drained, so a stall holds every stage in place. The user must write calibration
// words through the csr port while no beat is in flight (unenforced); stages read them directly.
module pressure_temperature_compensation
   import ptc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // config write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data,
   // request: [15:0] raw_temperature, [39:16] raw_pressure
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [39:0]            req_tdata,
   // response: [31:0] temperature_tenths, [63:32] pressure_pa
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata,
   // response flag: [0] divide_error
   output logic                   rsp_tuser
);

   localparam int DIV1_SIDE_W = 32 + 24 + 2;
   localparam int DIV2_SIDE_W = 32 + 2;

   // ---------------- configuration registers ----------------
   word_type   coef_ff [COEF_COUNT];
   logic [1:0] oss_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_COUNT; i++) coef_ff[i] <= '0;
         oss_ff <= OSS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_AC1_AC2: coef_ff[0] <= csr_data;
            CSR_AC3_AC4: coef_ff[1] <= csr_data;
            CSR_AC5_AC6: coef_ff[2] <= csr_data;
            CSR_B1_B2:   coef_ff[3] <= csr_data;
            CSR_MC_MD:   coef_ff[4] <= csr_data;
            CSR_OSS:     oss_ff     <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   word_type ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = sx16(coef_ff[0][31:16]);
   assign ac2 = sx16(coef_ff[0][15:0]);
   assign ac3 = sx16(coef_ff[1][31:16]);
   assign ac4 = {16'd0, coef_ff[1][15:0]};
   assign ac5 = {16'd0, coef_ff[2][31:16]};
   assign ac6 = {16'd0, coef_ff[2][15:0]};
   assign b1  = sx16(coef_ff[3][31:16]);
   assign b2  = sx16(coef_ff[3][15:0]);
   assign mc  = sx16(coef_ff[4][31:16]);
   assign md  = sx16(coef_ff[4][15:0]);

   // global advance: everything moves when the output register can take a beat
   logic en;
   logic rsp_tvalid_ff;
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // ---------------- stage 1: raw decode and first product ----------------
   logic        s1_v_ff;
   word_type    s1_prod_ff, s1_prod_in;
   logic [23:0] s1_up_ff, s1_up_in;

   assign s1_prod_in = mul32({16'd0, req_tdata[15:0]} - ac6, ac5);
   assign s1_up_in   = req_tdata[39:16] >> (4'd8 - {2'b0, oss_ff});

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (en) s1_v_ff <= req_tvalid;
      if (en) begin
         s1_prod_ff <= s1_prod_in;
         s1_up_ff   <= s1_up_in;
      end
   end

   // ---------------- temperature divider: x2 = mc*2048 / (x1 + md) ----------------
   word_type x1t, dt, nt, mag_n, mag_d;
   logic     err_t, neg_t;
   assign x1t   = sdiv_p2(s1_prod_ff, 15);
   assign dt    = x1t + md;
   assign err_t = dt == '0;
   assign nt    = mc << 11;
   assign neg_t = nt[31] ^ dt[31];
   assign mag_n = nt[31] ? -nt : nt;
   assign mag_d = dt[31] ? -dt : dt;

   logic                   d1_v;
   word_type               d1_q;
   logic [DIV1_SIDE_W-1:0] d1_side;

   ptc_udiv #(.WIDTH(32), .SIDE_W(DIV1_SIDE_W)) u_div_t (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s1_v_ff),
      .num      (mag_n),
      .den      (mag_d),
      .side_in  ({neg_t, err_t, s1_up_ff, x1t}),
      .out_valid(d1_v),
      .quo      (d1_q),
      .side_out (d1_side)
   );

   // ---------------- stage 3: b5, temperature, b6 ----------------
   word_type x2t, b5, s3_t_in, s3_b6_in;
   assign x2t      = d1_side[57] ? -d1_q : d1_q;
   assign b5       = d1_side[31:0] + x2t;
   assign s3_t_in  = sdiv_p2(b5 + K_ROUND_T, 4);
   assign s3_b6_in = b5 - T_OFFSET;

   logic        s3_v_ff, s3_err_ff;
   word_type    s3_t_ff, s3_b6_ff;
   logic [23:0] s3_up_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else if (en) s3_v_ff <= d1_v;
      if (en) begin
         s3_t_ff   <= s3_t_in;
         s3_b6_ff  <= s3_b6_in;
         s3_up_ff  <= d1_side[55:32];
         s3_err_ff <= d1_side[56];
      end
   end

   // ---------------- stage 4: products of b6 ----------------
   logic        s4_v_ff, s4_err_ff;
   word_type    s4_t_ff, s4_sq_ff, s4_p2_ff, s4_p3_ff;
   logic [23:0] s4_up_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else if (en) s4_v_ff <= s3_v_ff;
      if (en) begin
         s4_sq_ff  <= mul32(s3_b6_ff, s3_b6_ff);
         s4_p2_ff  <= mul32(ac2, s3_b6_ff);
         s4_p3_ff  <= mul32(ac3, s3_b6_ff);
         s4_t_ff   <= s3_t_ff;
         s4_up_ff  <= s3_up_ff;
         s4_err_ff <= s3_err_ff;
      end
   end

   // ---------------- stage 5: products of the square term ----------------
   word_type sq5;
   assign sq5 = asr32(s4_sq_ff, 12);

   logic        s5_v_ff, s5_err_ff;
   word_type    s5_t_ff, s5_m1_ff, s5_m2_ff, s5_x2a_ff, s5_x1b_ff;
   logic [23:0] s5_up_ff;

   always_ff @(posedge clock) begin
      if (reset) s5_v_ff <= 1'b0;
      else if (en) s5_v_ff <= s4_v_ff;
      if (en) begin
         s5_m1_ff  <= mul32(b2, sq5);
         s5_m2_ff  <= mul32(b1, sq5);
         s5_x2a_ff <= asr32(s4_p2_ff, 11);
         s5_x1b_ff <= asr32(s4_p3_ff, 13);
         s5_t_ff   <= s4_t_ff;
         s5_up_ff  <= s4_up_ff;
         s5_err_ff <= s4_err_ff;
      end
   end

   // ---------------- stage 6: b3 and the b4 multiplicand ----------------
   word_type x3a, b3_in, x3b, sum_in;
   assign x3a    = asr32(s5_m1_ff, 11) + s5_x2a_ff;
   assign b3_in  = sdiv_p2(((ac1 << 2) + x3a << oss_ff) + K_ROUND_B3, 2);
   assign x3b    = asr32(asr32(s5_m2_ff, 16) + s5_x1b_ff + K_ROUND_X3, 2);
   assign sum_in = x3b + K_32768;

   logic        s6_v_ff, s6_err_ff;
   word_type    s6_t_ff, s6_b3_ff, s6_sum_ff;
   logic [23:0] s6_up_ff;

   always_ff @(posedge clock) begin
      if (reset) s6_v_ff <= 1'b0;
      else if (en) s6_v_ff <= s5_v_ff;
      if (en) begin
         s6_b3_ff  <= b3_in;
         s6_sum_ff <= sum_in;
         s6_t_ff   <= s5_t_ff;
         s6_up_ff  <= s5_up_ff;
         s6_err_ff <= s5_err_ff;
      end
   end

   // ---------------- stage 7: b4 product, up - b3 ----------------
   logic     s7_v_ff, s7_err_ff;
   word_type s7_t_ff, s7_b4p_ff, s7_diff_ff;

   always_ff @(posedge clock) begin
      if (reset) s7_v_ff <= 1'b0;
      else if (en) s7_v_ff <= s6_v_ff;
      if (en) begin
         s7_b4p_ff  <= mul32(ac4, s6_sum_ff);
         s7_diff_ff <= {8'd0, s6_up_ff} - s6_b3_ff;
         s7_t_ff    <= s6_t_ff;
         s7_err_ff  <= s6_err_ff;
      end
   end

   // ---------------- stage 8: b4 and b7 ----------------
   word_type b4_in;
   assign b4_in = asr32(s7_b4p_ff, 15);

   logic     s8_v_ff, s8_err_ff;
   word_type s8_t_ff, s8_b4_ff, s8_b7_ff;

   always_ff @(posedge clock) begin
      if (reset) s8_v_ff <= 1'b0;
      else if (en) s8_v_ff <= s7_v_ff;
      if (en) begin
         s8_b4_ff  <= b4_in;
         s8_b7_ff  <= mul32(s7_diff_ff, K_50000 >> oss_ff);
         s8_t_ff   <= s7_t_ff;
         s8_err_ff <= s7_err_ff | (b4_in == '0);
      end
   end

   // ---------------- pressure divider: unsigned b7 branch kept ----------------
   logic     hi8;
   word_type n8;
   assign hi8 = s8_b7_ff[31];
   assign n8  = hi8 ? s8_b7_ff : s8_b7_ff << 1;

   logic                   d2_v;
   word_type               d2_q;
   logic [DIV2_SIDE_W-1:0] d2_side;

   ptc_udiv #(.WIDTH(32), .SIDE_W(DIV2_SIDE_W)) u_div_p (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s8_v_ff),
      .num      (n8),
      .den      (s8_b4_ff),
      .side_in  ({hi8, s8_err_ff, s8_t_ff}),
      .out_valid(d2_v),
      .quo      (d2_q),
      .side_out (d2_side)
   );

   // ---------------- stage 9..11: pressure polynomial ----------------
   word_type p9;
   assign p9 = d2_side[33] ? d2_q << 1 : d2_q;

   logic     s9_v_ff, s9_err_ff;
   word_type s9_t_ff, s9_p_ff, s9_x8_ff;

   always_ff @(posedge clock) begin
      if (reset) s9_v_ff <= 1'b0;
      else if (en) s9_v_ff <= d2_v;
      if (en) begin
         s9_p_ff   <= p9;
         s9_x8_ff  <= asr32(p9, 8);
         s9_t_ff   <= d2_side[31:0];
         s9_err_ff <= d2_side[32];
      end
   end

   logic     s10_v_ff, s10_err_ff;
   word_type s10_t_ff, s10_p_ff, s10_xx_ff, s10_px_ff;

   always_ff @(posedge clock) begin
      if (reset) s10_v_ff <= 1'b0;
      else if (en) s10_v_ff <= s9_v_ff;
      if (en) begin
         s10_xx_ff  <= mul32(s9_x8_ff, s9_x8_ff);
         s10_px_ff  <= mul32(K_NEG_7357, s9_p_ff);
         s10_p_ff   <= s9_p_ff;
         s10_t_ff   <= s9_t_ff;
         s10_err_ff <= s9_err_ff;
      end
   end

   logic     s11_v_ff, s11_err_ff;
   word_type s11_t_ff, s11_p_ff, s11_y_ff, s11_x2_ff;

   always_ff @(posedge clock) begin
      if (reset) s11_v_ff <= 1'b0;
      else if (en) s11_v_ff <= s10_v_ff;
      if (en) begin
         s11_y_ff   <= mul32(s10_xx_ff, K_3038);
         s11_x2_ff  <= asr32(s10_px_ff, 16);
         s11_p_ff   <= s10_p_ff;
         s11_t_ff   <= s10_t_ff;
         s11_err_ff <= s10_err_ff;
      end
   end

   // ---------------- output register ----------------
   word_type pf_in;
   assign pf_in = s11_p_ff + asr32(asr32(s11_y_ff, 16) + s11_x2_ff + K_3791, 4);

   logic [63:0] rsp_data_ff;
   logic        rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid_ff <= 1'b0;
      else if (en) rsp_tvalid_ff <= s11_v_ff;
      if (en) begin
         // a zero divisor anywhere forces both results to zero
         rsp_data_ff <= s11_err_ff ? '0 : {pf_in, s11_t_ff};
         rsp_err_ff  <= s11_err_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("error beat carries nonzero data");

   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      en && s11_v_ff |=> rsp_tvalid)
      else $error("finished beat lost at output register");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && !s1_v_ff && !s11_v_ff)
      else $error("pipeline not empty after reset");

endmodule
